>>> sv/mdio_c22_pkg.sv
package mdio_c22_pkg;

	// Frame length after the preamble, in MDC periods
	localparam int FRAME_BITS     = 34;
	localparam int PREAMBLE_DFLT  = 32;
	localparam int READ_FRAME_LEN = 19;

	// Request kinds carried by the input beat
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	// Fixed frame bits: start, opcode, turnaround
	localparam logic [4:0] RD_HEAD   = 5'b10110;
	localparam logic [3:0] WR_HEAD   = 4'b0101;
	localparam logic [1:0] WR_TA     = 2'b10;
	localparam logic [15:0] NO_PHY_DATA = 16'hffff;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  phy_address;
		logic [4:0]  register_address;
		logic [15:0] write_data;
		logic        line_in;
	} req_t;

	typedef struct packed {
		logic        line_out;
		logic        line_drive;
		logic        request_taken;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_result;
		logic        no_phy;
	} rsp_t;

endpackage

>>> sv/mdio_clause22_master_core.sv
// MDIO clause 22 management master, one input beat per MDC bit period.
//
// Input channel (in_valid / in_stall / in_data): each beat is one MDC
// period. It carries an optional read or write request, taken only while
// no transaction is running, and the MDIO level sampled in that period.
// Output channel (out_valid / out_stall / out_data): exactly one beat per
// input beat, giving the level and enable to drive on MDIO, busy/done
// flags and, with done on a read, the data or the no-PHY indication.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes preamble_enable,
// which is always ready; write it only while the block is idle.
//
// An input beat passes through the input register, then the shift/phase
// logic feeding the result register, on its way to the output beat.
// Throughput is one beat per cycle while out_stall stays low; the only loop
// is the phase counter and shift registers, updated once per beat.
// Reset clears the phase (idle), the shift registers and both stages,
// and sets preamble_enable to 1. When out_stall is high the result
// register holds; the input register still takes one more beat, after
// which in_stall rises until the result register drains.
module mdio_clause22_master_core #(
	parameter int PREAMBLE_BITS = mdio_c22_pkg::PREAMBLE_DFLT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mdio_c22_pkg::req_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mdio_c22_pkg::rsp_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import mdio_c22_pkg::*;

	localparam int PHASE_W = $clog2(FRAME_BITS + PREAMBLE_BITS + 1);
	localparam logic [PHASE_W-1:0] PH_FRAME = PHASE_W'(FRAME_BITS);
	localparam logic [PHASE_W-1:0] PH_FULL  = PHASE_W'(FRAME_BITS + PREAMBLE_BITS);
	localparam logic [PHASE_W-1:0] PH_RD_DRV = PHASE_W'(READ_FRAME_LEN);
	localparam logic [PHASE_W-1:0] PH_WR_DRV = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(1);

	// Input stage
	logic valid_s1;
	req_t item_s1;
	logic advance;

	// Transaction state
	logic               preamble_en_q;
	logic [PHASE_W-1:0] phase_q;
	logic               wr_q;
	logic [31:0]        cmd_q;
	logic [18:0]        rsh_q;

	// Next-state and result logic
	logic               start;
	logic [PHASE_W-1:0] phase_eff;
	logic               wr_eff;
	logic [31:0]        cmd_eff;
	logic [18:0]        rsh_eff;
	logic [PHASE_W-1:0] phase_nxt;
	logic [31:0]        cmd_nxt;
	logic [18:0]        rsh_nxt;
	logic               driven;
	rsp_t               rsp;

	// Move a beat out of the input register whenever the result register
	// is empty or being drained this cycle.
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		start = (phase_q == '0) &&
			((item_s1.kind == KIND_READ) || (item_s1.kind == KIND_WRITE));

		// Load the frame on a taken request, else continue the running one
		if (start) begin
			wr_eff    = (item_s1.kind == KIND_WRITE);
			phase_eff = preamble_en_q ? PH_FULL : PH_FRAME;
			rsh_eff   = '0;
			if (item_s1.kind == KIND_WRITE) begin
				cmd_eff = {WR_HEAD, item_s1.phy_address, item_s1.register_address,
					WR_TA, item_s1.write_data};
			end else begin
				cmd_eff = {RD_HEAD, item_s1.phy_address, item_s1.register_address,
					17'd0};
			end
		end else begin
			wr_eff    = wr_q;
			phase_eff = phase_q;
			rsh_eff   = rsh_q;
			cmd_eff   = cmd_q;
		end

		rsp       = '0;
		phase_nxt = phase_eff;
		cmd_nxt   = cmd_eff;
		rsh_nxt   = rsh_eff;
		driven    = wr_eff ? (phase_eff > PH_WR_DRV) : (phase_eff > PH_RD_DRV);
		rsp.request_taken = start;

		if (phase_eff != '0) begin
			rsp.busy_res = 1'b1;
			if (phase_eff > PH_FRAME) begin
				// Preamble: drive ones
				rsp.line_out   = 1'b1;
				rsp.line_drive = 1'b1;
			end else if (driven) begin
				rsp.line_out   = cmd_eff[31];
				rsp.line_drive = 1'b1;
				cmd_nxt        = {cmd_eff[30:0], 1'b0};
			end else if (!wr_eff) begin
				rsh_nxt = {rsh_eff[17:0], item_s1.line_in};
			end
			if (phase_eff == PH_LAST) begin
				rsp.done_res = 1'b1;
				if (!wr_eff) begin
					// Second turnaround bit high means nobody answered
					rsp.no_phy      = rsh_nxt[17];
					rsp.read_result = rsh_nxt[17] ? NO_PHY_DATA : rsh_nxt[16:1];
				end
			end
			phase_nxt = phase_eff - PH_LAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid     <= 1'b0;
			preamble_en_q <= 1'b1;
			phase_q       <= '0;
			wr_q          <= 1'b0;
			cmd_q         <= '0;
			rsh_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				preamble_en_q <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
				phase_q   <= phase_nxt;
				wr_q      <= wr_eff;
				cmd_q     <= cmd_nxt;
				rsh_q     <= rsh_nxt;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data <= rsp;
		end
	end

endmodule

>>> sv/mdio_c22_checker.sv
module mdio_c22_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input mdio_c22_pkg::rsp_t out_data
);
	import mdio_c22_pkg::*;

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// No-PHY read returns all ones
	a_nophy_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_phy |-> out_data.read_result == NO_PHY_DATA &&
			out_data.done_res)
		else $error("no_phy without all-ones data or done");

	// Done only inside a transaction
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.busy_res)
		else $error("done outside a transaction");

	// Released line reads as zero
	a_release_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.line_drive |-> !out_data.line_out)
		else $error("line_out high while released");

	// First period of a transaction always drives the line
	a_start_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.request_taken |-> out_data.busy_res &&
			out_data.line_drive && !out_data.done_res)
		else $error("taken request did not start driving");

endmodule

bind mdio_clause22_master_core mdio_c22_checker u_mdio_c22_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/sv/mdio_clause22_master_core_tb.sv
`timescale 1ns / 1ps

module mdio_clause22_master_core_tb;
	import mdio_c22_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int BLOCK_PERIODS = 30;

	// Tracks the management frame one MDC period at a time and holds the
	// output beats still owed by the block.
	class mdio_period_board;
		logic        pre_en = 1'b1;
		logic [6:0]  phase = '0;
		logic        op_wr = 1'b0;
		logic [31:0] cmd_bits = '0;
		logic [18:0] rd_bits = '0;
		rsp_t        owed_periods[$];
		int          noted = 0;
		int          checked = 0;
		int          failures = 0;
		int          reads = 0;
		int          writes = 0;
		int          absent_phy = 0;

		function int outstanding();
			return owed_periods.size();
		endfunction

		function void fail(string msg);
			failures++;
			if (failures <= 10)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		// Advance the frame by one period and queue the beat it must produce.
		function void note_period(req_t b);
			rsp_t r;
			int   f;
			r = '0;
			if (phase == 0 && (b.kind == KIND_READ || b.kind == KIND_WRITE)) begin
				r.request_taken = 1'b1;
				op_wr = (b.kind == KIND_WRITE);
				cmd_bits = op_wr ?
					{WR_HEAD, b.phy_address, b.register_address, WR_TA, b.write_data} :
					{RD_HEAD, b.phy_address, b.register_address, 17'd0};
				rd_bits = '0;
				phase = 7'(FRAME_BITS + (pre_en ? PREAMBLE_DFLT : 0));
			end
			if (phase != 0) begin
				r.busy_res = 1'b1;
				if (phase > FRAME_BITS) begin
					r.line_out = 1'b1;
					r.line_drive = 1'b1;
				end else begin
					f = FRAME_BITS - int'(phase);
					if (op_wr ? (f < 32) : (f < 15)) begin
						r.line_out = cmd_bits[31];
						r.line_drive = 1'b1;
						cmd_bits = cmd_bits << 1;
					end else if (!op_wr) begin
						rd_bits = {rd_bits[17:0], b.line_in};
					end
				end
				if (phase == 1) begin
					r.done_res = 1'b1;
					if (op_wr) begin
						writes++;
					end else begin
						reads++;
						r.no_phy = rd_bits[17];
						r.read_result = r.no_phy ? NO_PHY_DATA : rd_bits[16:1];
						if (r.no_phy)
							absent_phy++;
					end
				end
				phase = phase - 7'd1;
			end
			owed_periods.push_back(r);
			noted++;
		endfunction

		function void cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
			if (got_v !== want_v)
				fail($sformatf("beat %0d %s expected %h got %h", checked, name, want_v, got_v));
		endfunction

		function void check_period(rsp_t got);
			rsp_t want;
			if (owed_periods.size() == 0) begin
				fail($sformatf("output beat %h with nothing owed", got));
				return;
			end
			want = owed_periods.pop_front();
			cmp_field("line_out", want.line_out, got.line_out);
			cmp_field("line_drive", want.line_drive, got.line_drive);
			cmp_field("request_taken", want.request_taken, got.request_taken);
			cmp_field("busy_res", want.busy_res, got.busy_res);
			cmp_field("done_res", want.done_res, got.done_res);
			cmp_field("read_result", want.read_result, got.read_result);
			cmp_field("no_phy", want.no_phy, got.no_phy);
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	mdio_period_board sb = new();

	mdio_clause22_master_core #(
		.PREAMBLE_BITS(PREAMBLE_DFLT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver: pick the stall for the next edge at the falling edge, and
	// take a beat at each rising edge where it is valid and not stalled.
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_period(out_data);
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed",
				cycle_count, sb.outstanding());
			$display("mdio_clause22_master_core test failed");
			$finish;
		end
	end

	function automatic req_t random_period();
		req_t b;
		b.kind = KIND_PLAIN;
		b.phy_address = 5'($urandom);
		b.register_address = 5'($urandom);
		b.write_data = 16'($urandom);
		b.line_in = 1'($urandom);
		return b;
	endfunction

	// Play the PHY side of a read: answer the second turnaround bit with
	// ta2 and shift out pat MSB first; anything else is a random level.
	function automatic logic phy_level(logic [15:0] pat, logic ta2);
		int f;
		if (sb.phase == 0 || sb.op_wr || sb.phase > FRAME_BITS)
			return 1'($urandom);
		f = FRAME_BITS - int'(sb.phase);
		if (f == 16)
			return ta2;
		if (f >= 17 && f <= 32)
			return pat[32 - f];
		return 1'($urandom);
	endfunction

	// Present one period on the input channel and hold it until accepted.
	task automatic send_period(input req_t b);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = b;
		do @(posedge clk); while (in_stall);
		sb.note_period(b);
	endtask

	// Drop valid and wait until every owed beat has come back.
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_preamble(input logic en);
		quiesce();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = en;
		do @(posedge clk); while (!cfg_ready);
		sb.pre_en = en;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Issue one request from idle and clock the frame to its end. Periods
	// inside the frame carry stray requests at noise_pct.
	task automatic run_frame(input logic [1:0] kind, input logic [4:0] phy,
			input logic [4:0] regad, input logic [15:0] data,
			input logic [15:0] pat, input logic ta2, input int noise_pct);
		req_t b;
		b = random_period();
		b.kind = kind;
		b.phy_address = phy;
		b.register_address = regad;
		b.write_data = data;
		send_period(b);
		while (sb.phase != 0) begin
			b = random_period();
			if ($urandom_range(99) < noise_pct)
				b.kind = 2'($urandom_range(1, 3));
			b.line_in = phy_level(pat, ta2);
			send_period(b);
		end
	endtask

	task automatic idle_periods(input int n);
		req_t b;
		repeat (n) begin
			b = random_period();
			if ($urandom_range(3) == 0)
				b.kind = 2'd3;
			send_period(b);
		end
	endtask

	initial begin
		int start;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: address and data extremes, missing PHY, stray requests,
		// kind three while idle, with and without preamble.
		set_preamble(1'b1);
		run_frame(KIND_READ, 5'd31, 5'd31, 16'h0000, 16'hffff, 1'b0, 0);
		run_frame(KIND_READ, 5'd0, 5'd0, 16'hffff, 16'h0000, 1'b0, 0);
		run_frame(KIND_READ, 5'd7, 5'd19, 16'h0000, 16'h1234, 1'b1, 0);
		idle_periods(1);
		run_frame(KIND_WRITE, 5'd31, 5'd31, 16'hffff, 16'h0000, 1'b0, 0);
		run_frame(KIND_WRITE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b0, 100);
		run_frame(2'd3, 5'd5, 5'd5, 16'h0000, 16'h0000, 1'b0, 0);
		set_preamble(1'b0);
		run_frame(KIND_READ, 5'd21, 5'd10, 16'h0000, 16'ha5a5, 1'b0, 100);
		run_frame(KIND_WRITE, 5'd10, 5'd21, 16'h5a5a, 16'h0000, 1'b0, 0);
		run_frame(KIND_READ, 5'd31, 5'd0, 16'h0000, 16'h0000, 1'b1, 0);
		run_frame(KIND_WRITE, 5'd0, 5'd31, 16'h8001, 16'h0000, 1'b0, 0);

		// Random frames under each idling mode and both preamble settings.
		for (int m = 0; m < 4; m++) begin
			for (int p = 0; p < 2; p++) begin
				set_preamble(p == 0);
				case (m)
					0: begin sender_idle_pct = 0;  stall_pct = 0;  end
					1: begin sender_idle_pct = 82; stall_pct = 0;  end
					2: begin sender_idle_pct = 0;  stall_pct = 82; end
					default: begin sender_idle_pct = 38; stall_pct = 38; end
				endcase
				start = sb.noted;
				while (sb.noted - start < BLOCK_PERIODS) begin
					if ($urandom_range(9) < 8) begin
						run_frame(($urandom_range(1) == 0) ? KIND_READ : KIND_WRITE,
							5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
							($urandom_range(99) < 15), 10);
						idle_periods($urandom_range(2));
					end else begin
						idle_periods($urandom_range(1, 4));
					end
				end
			end
		end

		quiesce();
		$display("checked %0d MDC periods: %0d reads (%0d with no PHY), %0d writes",
			sb.checked, sb.reads, sb.absent_phy, sb.writes);
		$display("preamble on and off, four sender/receiver idling modes, %0d failures",
			sb.failures);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("mdio_clause22_master_core test passed");
		else
			$display("mdio_clause22_master_core test failed");
		$finish;
	end

endmodule
